/* rtl/crc_pkg.sv */
`timescale 1ns / 1ps

package crc_pkg;

    localparam int PROC_W = 6;
    localparam int MASK_W = 64;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_PAIR   = 2'd1,
        ACT_ROW    = 2'd2,
        ACT_COL    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_SWEEP,
        S_ROW,
        S_ROWDATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [PROC_W-1:0] rd_addr;
        logic              wr_en;
        logic [PROC_W-1:0] wr_addr;
    } t_mem_ctl;

endpackage

/* rtl/crc_if.sv */
`timescale 1ns / 1ps

interface crc_in_if;
    import crc_pkg::*;

    logic              valid;
    logic              ready;
    t_action           action;
    logic [PROC_W-1:0] first_proc;
    logic [PROC_W-1:0] second_proc;

    modport source (output valid, action, first_proc, second_proc, input ready);
    modport sink (input valid, action, first_proc, second_proc, output ready);
endinterface

interface crc_out_if;
    import crc_pkg::*;

    logic              valid;
    logic              ready;
    logic              reaches;
    logic [MASK_W-1:0] proc_mask;

    modport source (output valid, reaches, proc_mask, input ready);
    modport sink (input valid, reaches, proc_mask, output ready);
endinterface

/* rtl/crc_mem.sv */
`timescale 1ns / 1ps

module crc_mem #(
    parameter int NUM_PROCS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  crc_pkg::t_mem_ctl      i_ctl,
    input  logic [NUM_PROCS-1:0]   i_wr_data,
    output logic [NUM_PROCS-1:0]   o_rd_data
);
    import crc_pkg::*;

    localparam int AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

    logic [NUM_PROCS-1:0] r_mem [NUM_PROCS];
    logic [NUM_PROCS-1:0] r_vld;
    logic [NUM_PROCS-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr[AW-1:0]] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr[AW-1:0]];
        end
    end

    // row valid bits stand in for clearing the matrix at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_ctl.wr_addr[AW-1:0]] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_ctl.rd_addr[AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* rtl/crc_seq.sv */
`timescale 1ns / 1ps

module crc_seq #(
    parameter int NUM_PROCS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    crc_in_if.sink                 i_in,
    crc_out_if.source              o_out,
    output crc_pkg::t_mem_ctl      o_ctl,
    output logic [NUM_PROCS-1:0]   o_wr_data,
    input  logic [NUM_PROCS-1:0]   i_rd_data
);
    import crc_pkg::*;

    localparam int AW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

    t_state               r_state, n_state;
    t_action              r_act;
    logic [PROC_W-1:0]    r_a, r_b;
    logic [AW:0]          r_idx;
    logic [NUM_PROCS-1:0] r_gain, r_mask;
    logic                 r_reach;
    logic                 r_out_vld, r_out_reaches;
    logic [MASK_W-1:0]    r_out_mask;

    logic                 a_ok, b_ok;
    logic                 accept, out_free, sweep_end;
    logic [AW:0]          idx_m1;
    logic [AW-1:0]        prev_row;
    logic                 row_hit;

    assign a_ok      = 32'(i_in.first_proc) < NUM_PROCS;
    assign b_ok      = 32'(i_in.second_proc) < NUM_PROCS;
    assign accept    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_vld || o_out.ready;
    assign sweep_end = r_idx == (AW+1)'(NUM_PROCS);
    assign idx_m1    = r_idx - 1'b1;
    assign prev_row  = idx_m1[AW-1:0];
    // row just read holds the caller bit, or is the caller itself
    assign row_hit   = i_rd_data[r_a[AW-1:0]] || (prev_row == r_a[AW-1:0]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (i_in.action)
                        ACT_INSERT: n_state = (a_ok && b_ok) ? S_GAIN : S_DONE;
                        ACT_PAIR:   n_state = (a_ok && b_ok) ? S_ROW : S_DONE;
                        ACT_ROW:    n_state = a_ok ? S_ROW : S_DONE;
                        ACT_COL:    n_state = a_ok ? S_SWEEP : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_GAIN:    n_state = S_SWEEP;
            S_SWEEP:   n_state = sweep_end ? S_DONE : S_SWEEP;
            S_ROW:     n_state = S_ROWDATA;
            S_ROWDATA: n_state = S_DONE;
            S_DONE:    n_state = out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        i_in.ready = 1'b0;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_GAIN: begin
                o_ctl.rd_en   = 1'b1;
                o_ctl.rd_addr = r_b;
            end
            S_ROW: begin
                o_ctl.rd_en   = 1'b1;
                o_ctl.rd_addr = r_a;
            end
            S_SWEEP: begin
                o_ctl.rd_en   = !sweep_end;
                o_ctl.rd_addr = PROC_W'(r_idx[AW-1:0]);
                o_ctl.wr_en   = (r_act == ACT_INSERT) && (r_idx != '0) && row_hit;
                o_ctl.wr_addr = PROC_W'(prev_row);
            end
            default: ;
        endcase
    end

    assign o_wr_data = i_rd_data | r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= i_in.action;
            r_a     <= i_in.first_proc;
            r_b     <= i_in.second_proc;
            r_idx   <= '0;
            r_mask  <= '0;
            r_reach <= 1'b0;
        end
        if (r_state == S_SWEEP) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == '0) begin
                // callee row arrives first: callee plus all it reaches
                r_gain <= i_rd_data | ({{(NUM_PROCS-1){1'b0}}, 1'b1} << r_b[AW-1:0]);
            end else if (r_act == ACT_COL) begin
                r_mask[prev_row] <= i_rd_data[r_a[AW-1:0]];
            end
        end
        if (r_state == S_ROWDATA) begin
            if (r_act == ACT_PAIR) begin
                r_reach <= i_rd_data[r_b[AW-1:0]];
            end else begin
                r_mask <= i_rd_data;
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out_reaches <= r_reach;
            r_out_mask    <= MASK_W'(r_mask);
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.reaches   = r_out_reaches;
    assign o_out.proc_mask = r_out_mask;

endmodule

/* rtl/call_reachability_closure_top.sv */
`timescale 1ns / 1ps
// insert: after accept, S_GAIN reads the callee row, then S_SWEEP reads every row of the memory, one
// row a cycle, and ORs the gain into each caller row; the reacher list runs S_SWEEP without S_GAIN;
// pair and reached-list queries read one row through S_ROW and S_ROWDATA; invalid indices go to S_DONE
// throughput: one word at a time, input ready returns in the cycle after the output loads
// reset: synchronous active-low i_rst_n clears all row valid bits, so the matrix reads as zero

module call_reachability_closure_top #(
    parameter int NUM_PROCS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crc_in_if.sink    i_in,
    crc_out_if.source o_out
);
    import crc_pkg::*;

    t_mem_ctl             mem_ctl;
    logic [NUM_PROCS-1:0] wr_data;
    logic [NUM_PROCS-1:0] rd_data;

    crc_mem #(
        .NUM_PROCS (NUM_PROCS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    crc_seq #(
        .NUM_PROCS (NUM_PROCS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_ctl     (mem_ctl),
        .o_wr_data (wr_data),
        .i_rd_data (rd_data)
    );

endmodule

/* rtl/crc_checker.sv */
`timescale 1ns / 1ps

module crc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_out_reaches,
    input logic [crc_pkg::MASK_W-1:0] i_out_mask
);
    import crc_pkg::*;

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after accept");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after accept");

    a_fields_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_reaches && (i_out_mask != '0)))
        else $error("pair bit and mask both set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_mask) && $stable(i_out_reaches))
        else $error("stalled output word changed");

endmodule

bind call_reachability_closure_top crc_checker u_crc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_reaches (o_out.reaches),
    .i_out_mask    (o_out.proc_mask)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import crc_pkg::*;

    localparam int NPROCS         = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_LEN       = 300;
    localparam int DRAIN_CYCLES   = 100;

    localparam logic [MASK_W-1:0] PROCS_ALL = {MASK_W{1'b1}} >> (MASK_W - NPROCS);

    typedef struct packed {
        logic              reaches;
        logic [MASK_W-1:0] proc_mask;
    } t_answer;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    crc_in_if  in_if ();
    crc_out_if out_if ();

    call_reachability_closure_top #(.NUM_PROCS(NPROCS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted closure: row i holds every procedure that i reaches
    logic [MASK_W-1:0] closure_rows [NPROCS];
    t_answer           pending_answers [$];
    t_answer           want_answer;

    int send_idle_pct = 9;
    int recv_idle_pct = 56;
    int hold_token    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    function automatic bit proc_ok(logic [PROC_W-1:0] p);
        return int'(p) < NPROCS;
    endfunction

    function automatic t_answer predict_answer(t_action act, logic [PROC_W-1:0] a,
                                               logic [PROC_W-1:0] b);
        t_answer           ans;
        logic [MASK_W-1:0] gain;
        logic [MASK_W-1:0] callers;
        int                i;
        ans = '0;
        case (act)
            ACT_INSERT: begin
                if (proc_ok(a) && proc_ok(b)) begin
                    gain    = closure_rows[b];
                    gain[b] = 1'b1;
                    gain    = gain & PROCS_ALL;
                    callers = '0;
                    // callers taken from the matrix as it was before this word
                    for (i = 0; i < NPROCS; i++)
                        callers[i] = closure_rows[i][a] || (i == int'(a));
                    for (i = 0; i < NPROCS; i++)
                        if (callers[i]) closure_rows[i] = closure_rows[i] | gain;
                end
            end
            ACT_PAIR: begin
                if (proc_ok(a) && proc_ok(b)) ans.reaches = closure_rows[a][b];
            end
            ACT_ROW: begin
                if (proc_ok(a)) ans.proc_mask = closure_rows[a] & PROCS_ALL;
            end
            default: begin
                if (proc_ok(a)) begin
                    for (i = 0; i < NPROCS; i++)
                        ans.proc_mask[i] = closure_rows[i][a];
                end
            end
        endcase
        return ans;
    endfunction

    task automatic send_word(t_action act, logic [PROC_W-1:0] a, logic [PROC_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.action      <= act;
        in_if.first_proc  <= a;
        in_if.second_proc <= b;
        do @(posedge i_clk); while (!in_if.ready);
        pending_answers.push_back(predict_answer(act, a, b));
    endtask

    // result checking
    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            if (pending_answers.size() == 0) begin
                $error("output word with nothing pending: reaches %0b proc_mask %h",
                       out_if.reaches, out_if.proc_mask);
                mismatches++;
            end else begin
                want_answer = pending_answers.pop_front();
                if (out_if.reaches !== want_answer.reaches) begin
                    $error("reaches: expected %0b, actual %0b",
                           want_answer.reaches, out_if.reaches);
                    mismatches++;
                end
                if (out_if.proc_mask !== want_answer.proc_mask) begin
                    $error("proc_mask: expected %h, actual %h",
                           want_answer.proc_mask, out_if.proc_mask);
                    mismatches++;
                end
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen    <= hold_token;
            hold_left    <= HOLD_LEN;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_directed_cases();
        // empty matrix at both ends of the index range
        send_word(ACT_ROW, 6'd0, 6'd0);
        send_word(ACT_COL, 6'd63, 6'd63);
        send_word(ACT_PAIR, 6'd0, 6'd63);
        send_word(ACT_INSERT, 6'd0, 6'd63);
        send_word(ACT_PAIR, 6'd0, 6'd63);
        send_word(ACT_PAIR, 6'd63, 6'd0);
        // self call
        send_word(ACT_INSERT, 6'd63, 6'd63);
        send_word(ACT_ROW, 6'd63, 6'd0);
        send_word(ACT_COL, 6'd63, 6'd0);
        // a caller's ancestors must pick up the callee's descendants
        send_word(ACT_INSERT, 6'd10, 6'd11);
        send_word(ACT_INSERT, 6'd12, 6'd13);
        send_word(ACT_INSERT, 6'd11, 6'd12);
        send_word(ACT_PAIR, 6'd10, 6'd13);
        send_word(ACT_ROW, 6'd10, 6'd63);
        send_word(ACT_COL, 6'd13, 6'd0);
        // edge already implied
        send_word(ACT_INSERT, 6'd10, 6'd13);
        send_word(ACT_ROW, 6'd10, 6'd0);
        // closing a cycle
        send_word(ACT_INSERT, 6'd13, 6'd10);
        send_word(ACT_PAIR, 6'd12, 6'd11);
        send_word(ACT_PAIR, 6'd11, 6'd11);
        send_word(ACT_COL, 6'd10, 6'd63);
        send_word(ACT_INSERT, 6'd62, 6'd0);
        send_word(ACT_ROW, 6'd62, 6'd0);
        send_word(ACT_COL, 6'd0, 6'd0);
    endtask

    task automatic test_random_traffic(int count, int lo, int hi);
        int      kind;
        int      a;
        int      b;
        t_action act;
        repeat (count) begin
            kind = $urandom_range(99);
            if (kind < 20) begin
                act  = ACT_INSERT;
                kind = $urandom_range(99);
                a    = $urandom_range(hi, lo);
                if (kind < 80) begin
                    // short forward calls keep the closure sparse for a while
                    b = a + $urandom_range(4, 1);
                    if (b > hi) b = hi;
                end else if (kind < 92) begin
                    b = $urandom_range(hi, lo);
                end else if (kind < 97) begin
                    b = a;
                end else begin
                    a = $urandom_range(63);
                    b = $urandom_range(63);
                end
            end else begin
                act = t_action'(2'($urandom_range(3, 1)));
                a   = $urandom_range(1) ? $urandom_range(hi, lo) : $urandom_range(63);
                b   = $urandom_range(1) ? $urandom_range(hi, lo) : $urandom_range(63);
            end
            send_word(act, a[PROC_W-1:0], b[PROC_W-1:0]);
        end
    endtask

    task automatic test_output_backpressure();
        int a;
        hold_token <= hold_token + 1;
        repeat (12) begin
            a = $urandom_range(63);
            send_word($urandom_range(1) ? ACT_COL : ACT_PAIR, a[PROC_W-1:0],
                      6'($urandom_range(63)));
        end
    endtask

    initial begin
        int i;
        in_if.valid       = 1'b0;
        in_if.action      = ACT_INSERT;
        in_if.first_proc  = '0;
        in_if.second_proc = '0;
        out_if.ready      = 1'b0;
        for (i = 0; i < NPROCS; i++)
            closure_rows[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(360, 0, 20);

        send_idle_pct = 56;
        recv_idle_pct <= 9;
        test_random_traffic(360, 21, 41);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_random_traffic(360, 42, 63);
        test_output_backpressure();

        in_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/crc_pkg.sv
rtl/crc_if.sv
rtl/crc_mem.sv
rtl/crc_seq.sv
rtl/call_reachability_closure_top.sv
rtl/crc_checker.sv
bench/tb.sv
